### design/uuidp_pkg.sv
// types and constants shared by the uuid text parser modules
package uuidp_pkg;

  localparam int unsigned UUID_LEN = 36;
  localparam int unsigned POS_SAT  = 37;
  localparam int unsigned POS_W    = 6;

  localparam logic [7:0] CH_DASH = 8'h2d;

  localparam logic [POS_W-1:0] DASH_POS_0 = 6'd8;
  localparam logic [POS_W-1:0] DASH_POS_1 = 6'd13;
  localparam logic [POS_W-1:0] DASH_POS_2 = 6'd18;
  localparam logic [POS_W-1:0] DASH_POS_3 = 6'd23;
  localparam logic [POS_W-1:0] POS_LAST   = 6'(UUID_LEN - 1);
  localparam logic [POS_W-1:0] POS_END    = 6'(UUID_LEN);
  localparam logic [POS_W-1:0] POS_MAX    = 6'(POS_SAT);

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_NIL = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [63:0] id_high;
    logic [63:0] id_low;
  } out_item_t;

  // verdict on one character at one position
  typedef struct packed {
    logic       err;
    logic       shift;
    logic [3:0] nibble;
  } char_class_t;

endpackage

### design/uuidp_char_check.sv
// checks one character against its position in the uuid text
module uuidp_char_check (
  input  logic [7:0]                     ch,
  input  logic [uuidp_pkg::POS_W-1:0]    pos,
  output uuidp_pkg::char_class_t         cls
);
  import uuidp_pkg::*;

  logic is_digit;
  logic is_letter;
  logic dash_pos;

  always_comb begin
    is_digit  = ch inside {[8'h30:8'h39]};
    is_letter = ch inside {[8'h61:8'h66]};
    dash_pos  = pos inside {DASH_POS_0, DASH_POS_1, DASH_POS_2, DASH_POS_3};

    cls.err    = 1'b0;
    cls.shift  = 1'b0;
    cls.nibble = is_letter ? ch[3:0] + 4'd9 : ch[3:0];

    if (pos >= POS_END) begin
      cls.err = 1'b1;
    end else if (dash_pos) begin
      cls.err = (ch != CH_DASH);
    end else if (is_digit || is_letter) begin
      cls.shift = 1'b1;
    end else begin
      cls.err = 1'b1;
    end
  end

endmodule

### design/uuid_text_parser.sv
// top level of the streaming canonical uuid text parser
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | in_valid / in_stall  | in_item  : ch (8b byte), last (1b)
//  result   | out_valid / out_stall| out_item : status (2b), id_high, id_low
//
// one item accepted per cycle at full rate, while in_stall is low; after the
// last character of a string is accepted, its result passes through the input
// register, then the result register. the only loop is the position/error/
// accumulator update. reset clears the position, error flag, accumulator and
// both valid flags. a stalled result holds in the result register; strings
// that are not ending keep flowing past it, and the input stalls only when
// a last character meets a result register that is occupied and stalled.
module uuid_text_parser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  uuidp_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output uuidp_pkg::out_item_t  out_item
);
  import uuidp_pkg::*;

  // input register
  logic        s1_valid_r, s1_valid_nxt;
  in_item_t    s1_item_r;
  logic        s1_fire;

  // parse state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             err_r, err_nxt;
  logic [127:0]     acc_r, acc_nxt;

  // result register
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;

  char_class_t cls;
  logic        any_err;
  logic [127:0] acc_shift;

  // the stage-1 item moves on unless it ends a string and a held result is stalled
  assign s1_fire  = s1_valid_r && (!s1_item_r.last || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;

  assign s1_valid_nxt = (in_valid && !in_stall) || (s1_valid_r && !s1_fire);

  uuidp_char_check u_check (
    .ch  (s1_item_r.ch),
    .pos (pos_r),
    .cls (cls)
  );

  // next parse state and result
  always_comb begin
    acc_shift = {acc_r[123:0], cls.nibble};
    any_err   = err_r | cls.err;

    pos_nxt = pos_r;
    err_nxt = err_r;
    acc_nxt = acc_r;
    out_item_nxt = out_item_r;

    if (s1_fire) begin
      err_nxt = any_err;
      if (cls.shift) begin
        acc_nxt = acc_shift;
      end
      if (pos_r < POS_MAX) begin
        pos_nxt = pos_r + 6'd1;
      end

      if (s1_item_r.last) begin
        // end of string: report and start over
        out_item_nxt.id_high = '0;
        out_item_nxt.id_low  = '0;
        if (any_err || pos_r != POS_LAST) begin
          out_item_nxt.status = ST_BAD;
        end else if (acc_nxt == '0) begin
          out_item_nxt.status = ST_NIL;
        end else begin
          out_item_nxt.status  = ST_OK;
          out_item_nxt.id_high = acc_nxt[127:64];
          out_item_nxt.id_low  = acc_nxt[63:0];
        end
        pos_nxt = '0;
        err_nxt = 1'b0;
        acc_nxt = '0;
      end
    end
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || (s1_fire && s1_item_r.last);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      err_r       <= 1'b0;
      acc_r       <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      err_r       <= err_nxt;
      acc_r       <= acc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_item;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // position counter saturates and never passes its cap
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_MAX)
    else $error("position counter above saturation value");

  // a finished string leaves the parse state cleared
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_item_r.last) |=> (pos_r == '0 && !err_r && acc_r == '0))
    else $error("parse state not cleared after last character");

  // an ok result never carries the nil identifier
  a_ok_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_OK) |-> (out_item.id_high != '0 ||
                                                 out_item.id_low != '0))
    else $error("ok result with all-zero identifier");

  // bad and nil results carry a zero identifier
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.id_high == '0 &&
                                                 out_item.id_low == '0))
    else $error("failed result with nonzero identifier");

endmodule
